[sv/blended_cdf_index_search_defines.svh]
// Assertion macros shared by the blended CDF search block.
`ifndef BLENDED_CDF_INDEX_SEARCH_DEFINES_SVH
`define BLENDED_CDF_INDEX_SEARCH_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define BCDF_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check that a trigger is followed in the next cycle by a consequence.
`define BCDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[sv/bcdf_pkg.sv]
// Types and constants shared by the blended CDF search block.
package bcdf_pkg;

    localparam int TABLE_DEPTH          = 1024;
    localparam int ADDR_W               = $clog2(TABLE_DEPTH);
    localparam int CNT_W                = ADDR_W + 1;
    localparam int IDX_W                = CNT_W + 1;
    localparam int WEIGHT_FRACTION_BITS = 16;
    localparam int WEIGHT_W             = 17;
    localparam int VAL_W                = 32;
    localparam int INDEX_W              = 10;
    localparam int CFG_W                = 11;
    localparam int RES_W                = 11;
    localparam int DIFF_W               = VAL_W + 1;
    localparam int PROD_W               = DIFF_W + WEIGHT_W + 1;
    localparam int BLEND_W              = PROD_W + 1;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [RES_W-1:0] RES_NONE = {RES_W{1'b1}};

    // Step of one entry on the signed search bounds
    localparam logic signed [IDX_W-1:0] IDX_ONE = IDX_W'(1);

    typedef struct packed {
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
    } t_entry;

    // Blended value against the key
    typedef struct packed {
        logic le;
        logic lt;
    } t_cmp;

endpackage

[sv/bcdf_channels.sv]
// Handshake channels of the blended CDF search block.
interface bcdf_item_if import bcdf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                action;
    logic [INDEX_W-1:0]  entry_index;
    logic [VAL_W-1:0]    a_value;
    logic [VAL_W-1:0]    b_value;
    logic [VAL_W-1:0]    search_key;
    logic [WEIGHT_W-1:0] blend_weight;

    modport source (output valid, action, entry_index, a_value, b_value, search_key,
                    blend_weight, input ready);
    modport sink   (input valid, action, entry_index, a_value, b_value, search_key,
                    blend_weight, output ready);
endinterface

interface bcdf_result_if import bcdf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] found_index;

    modport source (output valid, found_index, input ready);
    modport sink   (input valid, found_index, output ready);
endinterface

interface bcdf_cfg_if import bcdf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] entries_in_use;

    modport source (output valid, entries_in_use, input ready);
    modport sink   (input valid, entries_in_use, output ready);
endinterface

[sv/bcdf_mem.sv]
// Entry memory holding both CDF rows, one write and one registered read port.
module bcdf_mem import bcdf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_entry            i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output t_entry            o_rdata
);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/bcdf_blend.sv]
// Shared blend unit: registered multiply, then add and compare with the key.
module bcdf_blend import bcdf_pkg::*; (
    input  logic                i_clk,
    input  t_entry              i_entry,
    input  logic [WEIGHT_W-1:0] i_weight,
    input  logic [VAL_W-1:0]    i_key,
    output t_cmp                o_cmp
);

    logic signed [DIFF_W-1:0]   diff;
    logic signed [WEIGHT_W:0]   weight_s;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   r_prod;
    logic        [VAL_W-1:0]    r_a;
    logic signed [PROD_W-1:0]   part;
    logic signed [BLEND_W-1:0]  blend;
    logic signed [BLEND_W-1:0]  key_s;

    assign diff     = $signed({1'b0, i_entry.b}) - $signed({1'b0, i_entry.a});
    assign weight_s = $signed({1'b0, i_weight});
    assign prod     = diff * weight_s;

    always_ff @(posedge i_clk) begin
        r_prod <= prod;
        r_a    <= i_entry.a;
    end

    // Arithmetic shift floors toward minus infinity, as the blend requires
    assign part  = r_prod >>> WEIGHT_FRACTION_BITS;
    assign blend = $signed({{(BLEND_W-VAL_W){1'b0}}, r_a}) + BLEND_W'(part);
    assign key_s = $signed({{(BLEND_W-VAL_W){1'b0}}, i_key});

    assign o_cmp.le = (blend <= key_s);
    assign o_cmp.lt = (blend <  key_s);

endmodule

[sv/blended_cdf_index_search.sv]
// Blended CDF index search: two CDF rows in one entry memory, binary search
// over a per-query blend of the rows. A write item (action 0) stores a_value
// and b_value at entry_index and gives no result. A query item
// (action 1) finds the last index whose blended value
// A[i] + floor((B[i]-A[i]) * w / 2^16) is at most search_key, -1 when the key
// lies below entry 0 or the table is empty, and entries_in_use-1 when it is at
// or above the last entry; counts above the table depth act as the depth.
// A query occupies the block through P probes, where P is at most about
// log2(entries_in_use)+1 (11 at 1024 entries), and also while the output
// register still holds an earlier result. Each probe reads the entry at mid
// and then at mid+1 through the single read port of the entry memory, and
// both go through the one shared multiply-add-compare unit, in the states
// S_ADDR, S_NEXT, S_HERE and S_DECIDE. The input side is ready only between
// items; the result sits in an output register, so a query may be accepted
// while the previous result is still waiting to be taken. entries_in_use is
// written through the configuration channel, which is always ready; write it
// only while no query is in flight. Rows are undefined until written, and a
// query must only touch written entries.
`include "blended_cdf_index_search_defines.svh"

module blended_cdf_index_search import bcdf_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bcdf_cfg_if.sink     i_cfg,
    bcdf_item_if.sink    i_item,
    bcdf_result_if.source o_result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDR,
        S_NEXT,
        S_HERE,
        S_DECIDE,
        S_DONE
    } t_state;

    t_state                    r_state, n_state;
    logic [CFG_W-1:0]          r_entries;
    logic [CNT_W-1:0]          r_size, n_size;
    logic [VAL_W-1:0]          r_key, n_key;
    logic [WEIGHT_W-1:0]       r_weight, n_weight;
    logic signed [IDX_W-1:0]   r_left, n_left;
    logic signed [IDX_W-1:0]   r_right, n_right;
    logic [CNT_W-1:0]          r_mid, n_mid;
    t_cmp                      r_here, n_here;
    logic [RES_W-1:0]          r_res, n_res;
    logic                      r_out_valid, n_out_valid;
    logic [RES_W-1:0]          r_out_index, n_out_index;

    logic                      item_acc;
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_raddr;
    t_entry                    mem_wdata;
    t_entry                    mem_rdata;
    t_cmp                      blend_cmp;
    logic [CNT_W-1:0]          clamped_size;
    logic [IDX_W-1:0]          sum_lr;
    logic [CNT_W-1:0]          mid_plus;
    logic signed [IDX_W-1:0]   mid_s;
    logic                      below_next;

    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = (r_state == S_IDLE);
    assign item_acc     = i_item.valid && i_item.ready;

    assign o_result.valid       = r_out_valid;
    assign o_result.found_index = $signed(r_out_index);

    // Counts above the table depth act as the depth
    assign clamped_size = (r_entries > CFG_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                            : CNT_W'(r_entries);

    // Write items land directly in the memory
    assign mem_we      = item_acc && (i_item.action == ACT_WRITE) &&
                         ({1'b0, i_item.entry_index} < (INDEX_W+1)'(TABLE_DEPTH));
    assign mem_wdata.a = i_item.a_value;
    assign mem_wdata.b = i_item.b_value;

    assign sum_lr     = r_left + r_right;
    assign mid_plus   = r_mid + 1'b1;
    assign mid_s      = $signed({1'b0, r_mid});
    // The last entry has no successor: treat the next value as infinity
    assign below_next = (mid_plus == r_size) || !blend_cmp.le;

    bcdf_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (i_item.entry_index[ADDR_W-1:0]),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bcdf_blend u_blend (
        .i_clk    (i_clk),
        .i_entry  (mem_rdata),
        .i_weight (r_weight),
        .i_key    (r_key),
        .o_cmp    (blend_cmp)
    );

    always_comb begin
        n_state     = r_state;
        n_size      = r_size;
        n_key       = r_key;
        n_weight    = r_weight;
        n_left      = r_left;
        n_right     = r_right;
        n_mid       = r_mid;
        n_here      = r_here;
        n_res       = r_res;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_index = r_out_index;
        mem_raddr   = r_mid[ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (item_acc && (i_item.action == ACT_QUERY)) begin
                    n_key    = i_item.search_key;
                    n_weight = i_item.blend_weight;
                    n_size   = clamped_size;
                    n_left   = '0;
                    n_right  = $signed({1'b0, clamped_size}) - IDX_ONE;
                    if (clamped_size == '0) begin
                        n_res   = RES_NONE;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_ADDR;
                    end
                end
            end
            S_ADDR: begin
                // Probe the middle of the live range
                n_mid     = sum_lr[IDX_W-1:1];
                mem_raddr = sum_lr[ADDR_W:1];
                n_state   = S_NEXT;
            end
            S_NEXT: begin
                mem_raddr = mid_plus[ADDR_W-1:0];
                n_state   = S_HERE;
            end
            S_HERE: begin
                // Blend of the probed entry is out; hold its compare flags
                n_here  = blend_cmp;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (r_here.le && below_next) begin
                    n_res   = RES_W'(r_mid);
                    n_state = S_DONE;
                end else begin
                    if (r_here.lt) begin
                        n_left = $signed({1'b0, mid_plus});
                    end else begin
                        n_right = mid_s - IDX_ONE;
                    end
                    if ((r_here.lt ? $signed({1'b0, mid_plus}) : r_left) >
                        (r_here.lt ? r_right : mid_s - IDX_ONE)) begin
                        // Range ran dry: below everything or past the end
                        n_res   = (r_mid == '0) ? RES_NONE : RES_W'(r_size - 1'b1);
                        n_state = S_DONE;
                    end else begin
                        n_state = S_ADDR;
                    end
                end
            end
            S_DONE: begin
                // Wait for the output register to free up
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    n_out_index = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_entries   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_entries <= i_cfg.entries_in_use;
            end
        end
        r_size      <= n_size;
        r_key       <= n_key;
        r_weight    <= n_weight;
        r_left      <= n_left;
        r_right     <= n_right;
        r_mid       <= n_mid;
        r_here      <= n_here;
        r_res       <= n_res;
        r_out_index <= n_out_index;
    end

    `BCDF_ASSERT_NEXT(a_empty_query,
        item_acc && (i_item.action == ACT_QUERY) && (clamped_size == '0),
        (r_state == S_DONE) && (r_res == RES_NONE),
        "empty table query must answer none")
    `BCDF_ASSERT_NOW(a_probe_range,
        (r_state != S_ADDR) || (r_left <= r_right),
        "probe issued on an empty range")
    `BCDF_ASSERT_NOW(a_result_bound,
        (r_state != S_DONE) || (r_res == RES_NONE) || (r_res < RES_W'(r_size)),
        "result index beyond the searched entries")
    `BCDF_ASSERT_NEXT(a_write_stays_idle,
        item_acc && (i_item.action == ACT_WRITE),
        (r_state == S_IDLE),
        "write item left the idle state")

endmodule

[sim/cdf_index_checker.sv]
// Checker for the blended CDF search: tracks rows and entry count, predicts and compares.
module cdf_index_checker import bcdf_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    bcdf_cfg_if    i_cfg,
    bcdf_item_if   i_item,
    bcdf_result_if i_result,
    output int     o_failures,
    output int     o_waiting
);

    typedef struct {
        logic [VAL_W-1:0]        key;
        logic [WEIGHT_W-1:0]     weight;
        logic signed [RES_W-1:0] index;
    } t_lookup;

    logic [VAL_W-1:0] row_a [TABLE_DEPTH];
    logic [VAL_W-1:0] row_b [TABLE_DEPTH];
    logic [CFG_W-1:0] entries_in_use;
    t_lookup          pending_lookups [$];

    // Row blend at one entry, floor division by the weight scale, exact in 64 bits.
    function automatic longint blended_value(input int pos, input logic [WEIGHT_W-1:0] w);
        longint base;
        longint delta;
        longint prod;
        longint part;
        base  = longint'(row_a[pos]);
        delta = longint'(row_b[pos]) - base;
        prod  = delta * longint'(w);
        if (prod >= 0) begin
            part = prod >>> WEIGHT_FRACTION_BITS;
        end else begin
            part = -((-prod + (longint'(1) << WEIGHT_FRACTION_BITS) - 1)
                     >>> WEIGHT_FRACTION_BITS);
        end
        return base + part;
    endfunction

    // Binary search for the last entry whose blend is at most the key.
    function automatic logic signed [RES_W-1:0] locate_key(input logic [VAL_W-1:0] key,
                                                           input logic [WEIGHT_W-1:0] w);
        int     span;
        int     lo;
        int     hi;
        int     mid;
        longint target;
        longint here;
        bit     below_next;
        span = (entries_in_use > TABLE_DEPTH) ? TABLE_DEPTH : int'(entries_in_use);
        if (span == 0) begin
            return RES_NONE;
        end
        target = longint'(key);
        lo     = 0;
        hi     = span - 1;
        mid    = 0;
        while (lo <= hi) begin
            mid  = (lo + hi) / 2;
            here = blended_value(mid, w);
            if (mid + 1 >= span) begin
                below_next = 1'b1;
            end else begin
                below_next = target < blended_value(mid + 1, w);
            end
            if (here <= target && below_next) begin
                return RES_W'(mid);
            end
            if (here < target) begin
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        return (mid == 0) ? RES_NONE : RES_W'(span - 1);
    endfunction

    always @(posedge i_clk) begin : watch
        t_lookup                 due;
        logic signed [RES_W-1:0] got;
        if (!i_rst_n) begin
            entries_in_use = '0;
            pending_lookups.delete();
            o_waiting = 0;
        end else begin
            if (i_result.valid && i_result.ready) begin
                got = i_result.found_index;
                if (pending_lookups.size() == 0) begin
                    o_failures++;
                    $display("%0t: result %0d arrived with no lookup outstanding", $time, got);
                end else begin
                    due = pending_lookups.pop_front();
                    if (got !== due.index) begin
                        o_failures++;
                        $display("%0t: key %h weight %0d: expected index %0d, got %0d",
                                 $time, due.key, due.weight, due.index, got);
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                entries_in_use = i_cfg.entries_in_use;
            end
            if (i_item.valid && i_item.ready) begin
                if (i_item.action == ACT_WRITE) begin
                    row_a[i_item.entry_index] = i_item.a_value;
                    row_b[i_item.entry_index] = i_item.b_value;
                end else begin
                    due.key    = i_item.search_key;
                    due.weight = i_item.blend_weight;
                    due.index  = locate_key(i_item.search_key, i_item.blend_weight);
                    pending_lookups.push_back(due);
                end
            end
            o_waiting = pending_lookups.size();
        end
    end

endmodule

[sim/testbench.sv]
// Top of the blended CDF search bench: clock, reset, stimulus, result pacing and verdict.
module testbench;
    import bcdf_pkg::*;

    // Stop making random phases once this many items have been accepted.
    localparam int ITEM_TARGET   = 1850;
    // Load the whole table once the item count passes this point.
    localparam int FULL_AFTER    = 400;
    // Wait this long after the last item before touching the count register.
    localparam int SETTLE_CYCLES = 4;
    // Quiet time after the last result, before the verdict.
    localparam int DRAIN_CYCLES  = 50;
    // Cycles without any handshake before the run is declared hung.
    localparam int IDLE_LIMIT    = 2000;
    localparam int WEIGHT_ONE    = 1 << WEIGHT_FRACTION_BITS;
    localparam int WEIGHT_MAX    = (1 << WEIGHT_W) - 1;
    localparam int COUNT_MAX     = (1 << CFG_W) - 1;

    typedef struct {
        logic                action;
        logic [INDEX_W-1:0]  entry_index;
        logic [VAL_W-1:0]    a_value;
        logic [VAL_W-1:0]    b_value;
        logic [VAL_W-1:0]    search_key;
        logic [WEIGHT_W-1:0] blend_weight;
    } cdf_item_t;

    logic clk = 1'b0;
    logic rst_n;
    int   failures;
    int   waiting;

    // When set, both sides run back to back with no gaps or stalls.
    bit   calm;
    // Current entry count and the length of the written prefix of the table.
    int   cfg_now;
    int   filled;
    int   n_items;
    int   n_writes;
    int   n_lookups;
    int   n_extrap;
    int   n_settings;
    int   widest;

    // Copy of the rows, used only to aim keys at blend boundaries.
    logic [VAL_W-1:0] shadow_a [TABLE_DEPTH];
    logic [VAL_W-1:0] shadow_b [TABLE_DEPTH];

    bcdf_cfg_if    cfg_ch ();
    bcdf_item_if   item_ch ();
    bcdf_result_if result_ch ();

    blended_cdf_index_search dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_cfg    (cfg_ch),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    cdf_index_checker index_check (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg      (cfg_ch),
        .i_item     (item_ch),
        .i_result   (result_ch),
        .o_failures (failures),
        .o_waiting  (waiting)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Drive one item: wait out a random gap, present it at a falling edge and hold it
    // until a rising edge sees ready. Valid stays high on return so that a following
    // item can replace it at the next falling edge without a bubble.
    task automatic send_item(input cdf_item_t it);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        @(negedge clk);
        if (gap > 0) begin
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.action       = it.action;
        item_ch.entry_index  = it.entry_index;
        item_ch.a_value      = it.a_value;
        item_ch.b_value      = it.b_value;
        item_ch.search_key   = it.search_key;
        item_ch.blend_weight = it.blend_weight;
        item_ch.valid        = 1'b1;
        do @(posedge clk); while (!item_ch.ready);
        n_items++;
        if (it.action == ACT_WRITE) begin
            n_writes++;
            shadow_a[it.entry_index] = it.a_value;
            shadow_b[it.entry_index] = it.b_value;
            // Grow the written prefix only when the write lands right at its end.
            if (int'(it.entry_index) == filled) begin
                filled++;
            end
        end else begin
            n_lookups++;
            if (it.blend_weight > WEIGHT_ONE) begin
                n_extrap++;
            end
        end
    endtask

    // Drop valid before any pause, so an accepted item is not taken twice.
    task automatic stop_items();
        @(negedge clk);
        item_ch.valid = 1'b0;
    endtask

    // Write one entry; fill the fields that a write ignores with noise.
    task automatic send_write(input int idx, input logic [VAL_W-1:0] a,
                              input logic [VAL_W-1:0] b);
        cdf_item_t it;
        it.action       = ACT_WRITE;
        it.entry_index  = INDEX_W'(idx);
        it.a_value      = a;
        it.b_value      = b;
        it.search_key   = $urandom;
        it.blend_weight = WEIGHT_W'($urandom_range(0, WEIGHT_MAX));
        send_item(it);
    endtask

    // Run one lookup; fill the fields that a lookup ignores with noise.
    task automatic send_lookup(input logic [VAL_W-1:0] key, input logic [WEIGHT_W-1:0] w);
        cdf_item_t it;
        it.action       = ACT_QUERY;
        it.entry_index  = INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
        it.a_value      = $urandom;
        it.b_value      = $urandom;
        it.search_key   = key;
        it.blend_weight = w;
        send_item(it);
    endtask

    // Change the entry count only with no lookup in flight and the last write retired.
    task automatic set_entries(input int count);
        stop_items();
        while (waiting != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_ch.entries_in_use = CFG_W'(count);
        cfg_ch.valid          = 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
        cfg_now = count;
        n_settings++;
        if (count > widest) begin
            widest = count;
        end
    endtask

    // Favor the exact endpoints and extrapolating weights, otherwise anywhere in [0, 1].
    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return WEIGHT_W'(WEIGHT_ONE);
            2: return WEIGHT_W'($urandom_range(WEIGHT_ONE + 1, WEIGHT_MAX));
            3: return WEIGHT_W'($urandom_range(0, 1) ? 1 : WEIGHT_ONE - 1);
            default: return WEIGHT_W'($urandom_range(0, WEIGHT_ONE));
        endcase
    endfunction

    // Mostly aim at the blend of a live entry, one below, on or one above it, so the
    // search lands on its boundaries; now and then take an extreme or a free key.
    function automatic logic [VAL_W-1:0] pick_key(input logic [WEIGHT_W-1:0] w);
        int     span;
        int     j;
        int     jit;
        longint aim;
        span = (cfg_now > TABLE_DEPTH) ? TABLE_DEPTH : cfg_now;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return $urandom;
            3: return 32'h8000_0000;
            default: ;
        endcase
        if (span == 0) begin
            return $urandom;
        end
        j   = $urandom_range(0, span - 1);
        aim = longint'(shadow_a[j])
              + (((longint'(shadow_b[j]) - longint'(shadow_a[j])) * longint'(w))
                 >>> WEIGHT_FRACTION_BITS);
        jit = int'($urandom_range(0, 2)) - 1;
        aim += jit;
        if (aim < 0) begin
            aim = 0;
        end else if (aim > longint'(32'hFFFF_FFFF)) begin
            aim = longint'(32'hFFFF_FFFF);
        end
        return aim[VAL_W-1:0];
    endfunction

    task automatic random_lookup();
        logic [WEIGHT_W-1:0] w;
        w = pick_weight();
        send_lookup(pick_key(w), w);
    endtask

    // Load entries 0..count-1. Monotone rows climb by random steps, with flat runs,
    // up to 2^31 or up to the top of the 32-bit range; otherwise the rows are scrambled.
    task automatic fill_rows(input int count, input bit monotone);
        logic [VAL_W-1:0] lim;
        logic [VAL_W-1:0] va;
        logic [VAL_W-1:0] vb;
        int unsigned      stride;
        lim    = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : 32'h8000_0000;
        va     = $urandom_range(0, 1 << 20);
        vb     = $urandom_range(0, 1 << 20);
        stride = (lim - (1 << 20)) / count;
        for (int i = 0; i < count; i++) begin
            if (monotone) begin
                send_write(i, va, vb);
                va += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, stride);
                vb += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, stride);
            end else begin
                send_write(i, $urandom_range(0, lim), $urandom_range(0, lim));
            end
        end
    endtask

    // Short table, a fresh count, a handful of lookups with stray writes mixed in.
    task automatic run_small_phase();
        int cnt;
        int setting;
        int nq;
        calm = ($urandom_range(0, 3) == 0);
        cnt  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(1, 24);
        fill_rows(cnt, $urandom_range(0, 6) != 0);
        case ($urandom_range(0, 9))
            0: setting = 0;
            1: setting = $urandom_range(1, cnt);
            2: setting = (filled == TABLE_DEPTH) ? $urandom_range(TABLE_DEPTH, COUNT_MAX) : cnt;
            3: setting = filled;
            default: setting = cnt;
        endcase
        set_entries(setting);
        nq = $urandom_range(4, 14);
        for (int k = 0; k < nq; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_write($urandom_range(0, TABLE_DEPTH - 1), $urandom, $urandom);
            end else begin
                random_lookup();
            end
        end
    endtask

    // Whole table once: counts of full depth, all ones, above depth, half depth or more.
    task automatic run_full_table();
        int sizes [4];
        int counts [4];
        sizes  = '{TABLE_DEPTH, COUNT_MAX, $urandom_range(TABLE_DEPTH + 1, COUNT_MAX - 1),
                   $urandom_range(TABLE_DEPTH / 2, TABLE_DEPTH - 1)};
        counts = '{16, 6, 4, 8};
        calm   = ($urandom_range(0, 3) == 0);
        fill_rows(TABLE_DEPTH, 1'b1);
        for (int s = 0; s < 4; s++) begin
            set_entries(sizes[s]);
            for (int k = 0; k < counts[s]; k++) begin
                random_lookup();
            end
        end
    endtask

    // Result side: per result either take it at once or hold ready low for a random
    // stall after it shows up.
    initial begin : result_pacing
        int stall;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 7);
            @(negedge clk);
            if (stall > 0) begin
                result_ch.ready = 1'b0;
                do @(posedge clk); while (result_ch.valid !== 1'b1);
                repeat (stall) @(negedge clk);
            end
            result_ch.ready = 1'b1;
            do @(posedge clk); while (result_ch.valid !== 1'b1);
        end
    end

    // Hang guard: count cycles in which no channel moves anything.
    initial begin : hang_guard
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (cfg_ch.valid && cfg_ch.ready)
                || (result_ch.valid && result_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: nothing accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        bit full_done;
        rst_n                 = 1'b0;
        item_ch.valid         = 1'b0;
        item_ch.action        = ACT_WRITE;
        item_ch.entry_index   = '0;
        item_ch.a_value       = '0;
        item_ch.b_value       = '0;
        item_ch.search_key    = '0;
        item_ch.blend_weight  = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.entries_in_use = '0;
        calm       = 1'b0;
        full_done  = 1'b0;
        cfg_now    = 0;
        filled     = 0;
        n_items    = 0;
        n_writes   = 0;
        n_lookups  = 0;
        n_extrap   = 0;
        n_settings = 0;
        widest     = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty table: the count comes out of reset as zero, then is written as zero.
        send_lookup('0, '0);
        send_lookup('1, WEIGHT_W'(WEIGHT_MAX));
        set_entries(0);
        send_lookup(32'h8000_0000, WEIGHT_W'(WEIGHT_ONE));

        // Four rising entries at the value extremes; entry 0 has B below A so the
        // blend difference goes negative. Touch the last table slot too.
        send_write(0, 32'h0000_0100, 32'h0000_0000);
        send_write(1, 32'h0000_1000, 32'h4000_0000);
        send_write(2, 32'h8000_0000, 32'h8000_0000);
        send_write(3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_write(TABLE_DEPTH - 1, 32'h0000_0000, 32'hFFFF_FFFF);
        set_entries(4);
        send_lookup(32'h0000_0000, '0);
        send_lookup(32'h0000_0000, WEIGHT_W'(WEIGHT_ONE));
        send_lookup('1, '0);
        send_lookup(32'h0000_0100, '0);
        send_lookup(32'h0000_00FF, '0);
        send_lookup(32'h4000_0000, WEIGHT_W'(WEIGHT_ONE / 2));
        send_lookup(32'h7FFF_FFFF, WEIGHT_W'(WEIGHT_MAX));
        send_lookup(32'h0000_0FFF, WEIGHT_W'(1));

        // Single entry table.
        set_entries(1);
        send_lookup(32'h0000_0100, '0);
        send_lookup(32'h0000_00FF, WEIGHT_W'(WEIGHT_MAX));

        // Break monotonicity at entry 1 and let the search walk it as it is.
        send_write(1, 32'hFFFF_0000, 32'h0000_0000);
        set_entries(3);
        send_lookup(32'h0001_0000, '0);
        send_lookup(32'h8000_0000, WEIGHT_W'(WEIGHT_ONE));

        // Random phases, mostly short tables, with one full-depth load partway through.
        while (n_items < ITEM_TARGET) begin
            if (!full_done && n_items >= FULL_AFTER) begin
                run_full_table();
                full_done = 1'b1;
            end else begin
                run_small_phase();
            end
        end

        // Drain: wait for every lookup to answer, then give the block time to misbehave.
        stop_items();
        while (waiting != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Ran %0d entry writes and %0d lookups (%0d with weight above one)",
                 n_writes, n_lookups, n_extrap);
        $display("across %0d entry-count settings, the largest %0d.", n_settings, widest);
        if (waiting != 0) begin
            $display("%0t: %0d lookups still without a result", $time, waiting);
        end
        if (failures == 0 && waiting == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
